// ===== rtl/class_priority_output_queue_macros.svh =====
// Assertion macros for the class priority output queue.
// Each use expects clk and rst_n in the enclosing module.
`ifndef CLASS_PRIORITY_OUTPUT_QUEUE_MACROS_SVH
`define CLASS_PRIORITY_OUTPUT_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define CPOQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CPOQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);
`else
`define CPOQ_ASSERT(label, prop, msg)
`define CPOQ_ASSERT_NEXT(label, trig, prop, msg)
`endif

`endif

// ===== rtl/cpoq_pkg.sv =====
`timescale 1ns / 1ps

package cpoq_pkg;

    localparam int OP_W       = 2;
    localparam int CLASS_W    = 3;
    localparam int HANDLE_W   = 32;
    localparam int LEN_IN_W   = 16;
    localparam int LEN_W      = 11;
    localparam int SLOT_NUM_W = 4;
    localparam int STATUS_W   = 3;
    localparam int CNT_OUT_W  = 5;
    localparam int TOTAL_W    = 32;
    localparam int RANK_W     = 3;

    localparam logic [CLASS_W-1:0] MAX_CLASS    = 3'd5;
    localparam logic [LEN_W-1:0]   BUFFER_LIMIT = 11'd1024;
    localparam logic [LEN_W-1:0]   LIMIT_RESET  = 11'd1016;
    localparam logic [RANK_W-1:0]  NO_RANK      = 3'd7;
    localparam logic [RANK_W-1:0]  FREE_RANK    = 3'd0;

    typedef enum logic [OP_W-1:0] {
        OP_SUBMIT = 2'd0,
        OP_SELECT = 2'd1,
        OP_RETIRE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 3'd0,
        STATUS_BAD_PARAM    = 3'd1,
        STATUS_TOO_LONG     = 3'd2,
        STATUS_BUSY         = 3'd3,
        STATUS_DROPPED      = 3'd4,
        STATUS_NONE_PENDING = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    length;
        logic [CLASS_W-1:0]  pclass;
    } entry_t;

    typedef struct packed {
        logic start;
        logic step;
        logic submit_mode;
        logic entry_valid;
    } scan_ctl_t;

    // Fixed class priority, lower is better
    function automatic logic [RANK_W-1:0] class_rank(input logic [CLASS_W-1:0] cls);
        logic [RANK_W-1:0] r;
        case (cls)
            3'd0:    r = 3'd3;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd1;
            3'd4:    r = 3'd0;
            3'd5:    r = 3'd4;
            3'd6:    r = 3'd3;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/cpoq_if.sv =====
`timescale 1ns / 1ps

interface cpoq_req_if import cpoq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [CLASS_W-1:0]    packet_class;
    logic [HANDLE_W-1:0]   packet_handle;
    logic [LEN_IN_W-1:0]   packet_length;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic                  dropped;

    modport source (
        output valid, operation, packet_class, packet_handle, packet_length,
               slot_number, dropped,
        input  ready
    );
    modport sink (
        input  valid, operation, packet_class, packet_handle, packet_length,
               slot_number, dropped,
        output ready
    );
endinterface

interface cpoq_rsp_if import cpoq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_NUM_W-1:0] chosen_slot;
    logic [HANDLE_W-1:0]   out_handle;
    logic [LEN_W-1:0]      out_length;
    logic [CLASS_W-1:0]    out_class;
    logic [CNT_OUT_W-1:0]  pending_count;
    logic [CNT_OUT_W-1:0]  high_water_mark;
    logic [TOTAL_W-1:0]    submitted_total;
    logic [TOTAL_W-1:0]    sent_total;
    logic [TOTAL_W-1:0]    rejected_total;
    logic [TOTAL_W-1:0]    failed_total;

    modport source (
        output valid, status, chosen_slot, out_handle, out_length, out_class,
               pending_count, high_water_mark, submitted_total, sent_total,
               rejected_total, failed_total,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_slot, out_handle, out_length, out_class,
               pending_count, high_water_mark, submitted_total, sent_total,
               rejected_total, failed_total,
        output ready
    );
endinterface

// ===== rtl/cpoq_slot_mem.sv =====
`timescale 1ns / 1ps

module cpoq_slot_mem import cpoq_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cpoq_scan.sv =====
`timescale 1ns / 1ps

module cpoq_scan import cpoq_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctl_t        ctl,
    input  logic [IDX_W-1:0] idx,
    input  entry_t           entry,
    output logic             found,
    output logic [IDX_W-1:0] best_idx,
    output entry_t           best_entry
);

    logic [RANK_W-1:0] best_key_reg;
    logic [RANK_W-1:0] best_key_next;
    logic [IDX_W-1:0]  best_idx_reg;
    entry_t            best_entry_reg;
    logic [RANK_W-1:0] key;
    logic              take;

    // Submit hunts for the first free slot, select for the best ranked
    // occupied slot; both are one strict less-than against the running best.
    always_comb
    begin
        if (ctl.submit_mode)
        begin
            key = ctl.entry_valid ? NO_RANK : FREE_RANK;
        end
        else
        begin
            key = ctl.entry_valid ? class_rank(entry.pclass) : NO_RANK;
        end
        take = ctl.step && (key < best_key_reg);
        if (ctl.start)
        begin
            best_key_next = NO_RANK;
        end
        else if (take)
        begin
            best_key_next = key;
        end
        else
        begin
            best_key_next = best_key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_key_reg <= NO_RANK;
        end
        else
        begin
            best_key_reg <= best_key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg   <= idx;
            best_entry_reg <= entry;
        end
    end

    assign found      = (best_key_reg != NO_RANK);
    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;

endmodule

// ===== rtl/class_priority_output_queue.sv =====
// Class priority output queue of SLOT_COUNT slots. Submit checks the request,
// then stores it in the lowest free slot; select reports the occupied slot
// with the best class priority (lowest slot wins a tie) without changing it;
// retire frees a slot as sent or dropped. Each request gives one response that
// also carries the running counters. Submit and select walk every slot through
// one shared rank compare, one slot a cycle, fed by the slot memory's registered
// read; they pass from idle through the scan and drain states to finish, while
// retire and unknown operation codes go from idle straight to finish. The
// response is registered as finish is left, and the next request is taken in idle.
// A request is taken while the previous response still waits on the response
// channel; the following response is held back until that one has gone. The
// payload limit register is written through cfg_we and cfg_wdata; the user must
// write it only while no request is in flight, and the block does not enforce it.
`timescale 1ns / 1ps
`include "class_priority_output_queue_macros.svh"

module class_priority_output_queue import cpoq_pkg::*; #(
    parameter int SLOT_COUNT = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    cpoq_req_if.sink         req,
    cpoq_rsp_if.source       rsp
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int CMP_W  = (CNT_W > SLOT_NUM_W) ? CNT_W : SLOT_NUM_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    state_t state_reg, state_next;

    logic [LEN_W-1:0]      limit_reg;
    logic [OP_W-1:0]       op_reg;
    logic [CLASS_W-1:0]    class_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [LEN_IN_W-1:0]   length_reg;
    logic [SLOT_NUM_W-1:0] slot_in_reg;
    logic                  dropped_reg;

    logic [SLOT_COUNT-1:0] slot_valid_reg, slot_valid_next;
    logic [SLOT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                  eval_en_reg;
    logic [SLOT_W-1:0]     eval_idx_reg;
    logic                  eval_valid_reg;

    logic [CNT_W-1:0]   pending_reg, pending_next;
    logic [CNT_W-1:0]   high_water_reg, high_water_next;
    logic [TOTAL_W-1:0] submitted_reg, submitted_next;
    logic [TOTAL_W-1:0] sent_reg, sent_next;
    logic [TOTAL_W-1:0] rejected_reg, rejected_next;
    logic [TOTAL_W-1:0] failed_reg, failed_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_NUM_W-1:0] chosen_reg, chosen_next;
    entry_t                out_entry_reg, out_entry_next;

    logic              accept;
    logic              finish_fire;
    logic [LEN_W-1:0]  limit_eff;
    logic              bad_param;
    logic              too_long;
    logic              retire_in_range;
    logic [SLOT_W-1:0] retire_idx;
    logic              retire_hit;
    logic              mem_wr_en;
    entry_t            mem_wr_data;
    entry_t            mem_rd_data;
    scan_ctl_t         scan_ctl;
    logic              scan_found;
    logic [SLOT_W-1:0] scan_best_idx;
    entry_t            scan_best_entry;

    assign accept      = req.valid && req.ready;
    assign finish_fire = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp.ready);

    assign scan_ctl.start       = accept;
    assign scan_ctl.step        = eval_en_reg;
    assign scan_ctl.submit_mode = (op_reg == OP_SUBMIT);
    assign scan_ctl.entry_valid = eval_valid_reg;

    cpoq_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (scan_best_idx),
        .wr_data (mem_wr_data),
        .rd_addr (scan_idx_reg),
        .rd_data (mem_rd_data)
    );

    cpoq_scan #(
        .IDX_W (SLOT_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .idx        (eval_idx_reg),
        .entry      (mem_rd_data),
        .found      (scan_found),
        .best_idx   (scan_best_idx),
        .best_entry (scan_best_entry)
    );

    // Submit checks, in order of precedence
    assign limit_eff = (limit_reg > BUFFER_LIMIT) ? BUFFER_LIMIT : limit_reg;
    assign bad_param = (class_reg > MAX_CLASS) || (handle_reg == '0) || (length_reg == '0);
    assign too_long  = (length_reg > LEN_IN_W'(limit_eff));

    assign retire_in_range = (CMP_W'(slot_in_reg) < CMP_W'(SLOT_COUNT));
    assign retire_idx      = SLOT_W'(slot_in_reg);
    assign retire_hit      = retire_in_range && slot_valid_reg[retire_idx];

    assign mem_wr_data.handle = handle_reg;
    assign mem_wr_data.length = LEN_W'(length_reg);
    assign mem_wr_data.pclass = class_reg;

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        slot_valid_next = slot_valid_reg;
        pending_next    = pending_reg;
        high_water_next = high_water_reg;
        submitted_next  = submitted_reg;
        sent_next       = sent_reg;
        rejected_next   = rejected_reg;
        failed_next     = failed_reg;
        status_next     = status_reg;
        chosen_next     = chosen_reg;
        out_entry_next  = out_entry_reg;
        mem_wr_en       = 1'b0;
        rsp_valid_next  = rsp.ready ? 1'b0 : rsp_valid_reg;
        req.ready       = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_idx_next = '0;
                    if ((req.operation == OP_SUBMIT) || (req.operation == OP_SELECT))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (finish_fire)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    status_next    = STATUS_BAD_PARAM;
                    chosen_next    = '0;
                    out_entry_next = '0;
                    case (op_reg)
                        OP_SUBMIT:
                        begin
                            if (bad_param)
                            begin
                                status_next = STATUS_BAD_PARAM;
                            end
                            else if (too_long)
                            begin
                                status_next = STATUS_TOO_LONG;
                            end
                            else if (scan_found)
                            begin
                                status_next                    = STATUS_OK;
                                chosen_next                    = SLOT_NUM_W'(scan_best_idx);
                                mem_wr_en                      = 1'b1;
                                slot_valid_next[scan_best_idx] = 1'b1;
                                pending_next                   = pending_reg + 1'b1;
                                submitted_next                 = submitted_reg + 1'b1;
                                if (pending_next > high_water_reg)
                                begin
                                    high_water_next = pending_next;
                                end
                            end
                            else
                            begin
                                status_next   = STATUS_BUSY;
                                rejected_next = rejected_reg + 1'b1;
                            end
                        end
                        OP_SELECT:
                        begin
                            if (scan_found)
                            begin
                                status_next    = STATUS_OK;
                                chosen_next    = SLOT_NUM_W'(scan_best_idx);
                                out_entry_next = scan_best_entry;
                            end
                            else
                            begin
                                status_next = STATUS_NONE_PENDING;
                            end
                        end
                        OP_RETIRE:
                        begin
                            chosen_next = slot_in_reg;
                            if (retire_hit)
                            begin
                                slot_valid_next[retire_idx] = 1'b0;
                                pending_next                = pending_reg - 1'b1;
                                if (dropped_reg)
                                begin
                                    status_next = STATUS_DROPPED;
                                    failed_next = failed_reg + 1'b1;
                                end
                                else
                                begin
                                    status_next = STATUS_OK;
                                    sent_next   = sent_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_BAD_PARAM;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= LIMIT_RESET;
            slot_valid_reg <= '0;
            scan_idx_reg   <= '0;
            eval_en_reg    <= 1'b0;
            pending_reg    <= '0;
            high_water_reg <= '0;
            submitted_reg  <= '0;
            sent_reg       <= '0;
            rejected_reg   <= '0;
            failed_reg     <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            slot_valid_reg <= slot_valid_next;
            scan_idx_reg   <= scan_idx_next;
            eval_en_reg    <= (state_reg == ST_SCAN);
            pending_reg    <= pending_next;
            high_water_reg <= high_water_next;
            submitted_reg  <= submitted_next;
            sent_reg       <= sent_next;
            rejected_reg   <= rejected_next;
            failed_reg     <= failed_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Hold the request fields and the per-slot valid bit alongside the memory read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.operation;
            class_reg   <= req.packet_class;
            handle_reg  <= req.packet_handle;
            length_reg  <= req.packet_length;
            slot_in_reg <= req.slot_number;
            dropped_reg <= req.dropped;
        end
        eval_idx_reg   <= scan_idx_reg;
        eval_valid_reg <= slot_valid_reg[scan_idx_reg];
        status_reg     <= status_next;
        chosen_reg     <= chosen_next;
        out_entry_reg  <= out_entry_next;
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.chosen_slot     = chosen_reg;
    assign rsp.out_handle      = out_entry_reg.handle;
    assign rsp.out_length      = out_entry_reg.length;
    assign rsp.out_class       = out_entry_reg.pclass;
    assign rsp.pending_count   = CNT_OUT_W'(pending_reg);
    assign rsp.high_water_mark = CNT_OUT_W'(high_water_reg);
    assign rsp.submitted_total = submitted_reg;
    assign rsp.sent_total      = sent_reg;
    assign rsp.rejected_total  = rejected_reg;
    assign rsp.failed_total    = failed_reg;

    `CPOQ_ASSERT(a_pending_tracks_valid, $countones(slot_valid_reg) == pending_reg, "pending count differs from occupied slots")
    `CPOQ_ASSERT(a_high_water_covers, high_water_reg >= pending_reg, "high-water mark below pending count")
    `CPOQ_ASSERT_NEXT(a_finish_returns_idle, finish_fire, (state_reg == ST_IDLE) && rsp_valid_reg, "response not presented after finish")

endmodule

// ===== test/cpoq_result_compare.sv =====
`timescale 1ns / 1ps

module cpoq_result_compare import cpoq_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    cpoq_req_if              req,
    cpoq_rsp_if              rsp,
    output int               mismatch_count,
    output int               awaiting_count,
    output int               checked_count
);

    localparam int SLOTS = 16;

    // Lower rank is served first
    localparam logic [RANK_W-1:0] RANK_OF [6] = '{3'd3, 3'd4, 3'd2, 3'd1, 3'd0, 3'd4};

    typedef struct packed {
        status_t               status;
        logic [SLOT_NUM_W-1:0] chosen;
        logic [HANDLE_W-1:0]   handle;
        logic [LEN_W-1:0]      length;
        logic [CLASS_W-1:0]    pclass;
        logic [CNT_OUT_W-1:0]  pending;
        logic [CNT_OUT_W-1:0]  high_water;
        logic [TOTAL_W-1:0]    submitted;
        logic [TOTAL_W-1:0]    sent;
        logic [TOTAL_W-1:0]    rejected;
        logic [TOTAL_W-1:0]    failed;
    } outcome_t;

    logic [LEN_W-1:0]     limit_reg;
    logic [SLOTS-1:0]     occupied;
    entry_t               store [SLOTS];
    logic [CNT_OUT_W-1:0] pending;
    logic [CNT_OUT_W-1:0] high_water;
    logic [TOTAL_W-1:0]   submitted;
    logic [TOTAL_W-1:0]   sent;
    logic [TOTAL_W-1:0]   rejected;
    logic [TOTAL_W-1:0]   failed;
    outcome_t             outcome_q [$];

    function automatic outcome_t serve_request(
        input logic [OP_W-1:0]       op,
        input logic [CLASS_W-1:0]    cls,
        input logic [HANDLE_W-1:0]   handle,
        input logic [LEN_IN_W-1:0]   len,
        input logic [SLOT_NUM_W-1:0] slot,
        input logic                  drop
    );
        outcome_t             o;
        logic [LEN_W-1:0]     cap;
        logic [RANK_W-1:0]    best_rank;
        int                   best;
        o = '0;
        o.status = STATUS_BAD_PARAM;
        case (op)
            OP_SUBMIT:
            begin
                cap = (limit_reg > BUFFER_LIMIT) ? BUFFER_LIMIT : limit_reg;
                if (cls > MAX_CLASS || handle == '0 || len == '0)
                    o.status = STATUS_BAD_PARAM;
                else if (len > cap)
                    o.status = STATUS_TOO_LONG;
                else
                begin
                    o.status = STATUS_BUSY;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!occupied[i] && o.status == STATUS_BUSY)
                        begin
                            occupied[i] = 1'b1;
                            store[i].handle = handle;
                            store[i].length = len[LEN_W-1:0];
                            store[i].pclass = cls;
                            pending = pending + 1'b1;
                            submitted = submitted + 1'b1;
                            if (pending > high_water)
                                high_water = pending;
                            o.status = STATUS_OK;
                            o.chosen = SLOT_NUM_W'(i);
                        end
                    end
                    if (o.status == STATUS_BUSY)
                        rejected = rejected + 1'b1;
                end
            end
            OP_SELECT:
            begin
                best = -1;
                best_rank = NO_RANK;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (occupied[i] && RANK_OF[store[i].pclass] < best_rank)
                    begin
                        best_rank = RANK_OF[store[i].pclass];
                        best = i;
                    end
                end
                if (best < 0)
                    o.status = STATUS_NONE_PENDING;
                else
                begin
                    o.status = STATUS_OK;
                    o.chosen = SLOT_NUM_W'(best);
                    o.handle = store[best].handle;
                    o.length = store[best].length;
                    o.pclass = store[best].pclass;
                end
            end
            OP_RETIRE:
            begin
                o.chosen = slot;
                if (occupied[slot])
                begin
                    occupied[slot] = 1'b0;
                    pending = pending - 1'b1;
                    if (drop)
                    begin
                        failed = failed + 1'b1;
                        o.status = STATUS_DROPPED;
                    end
                    else
                    begin
                        sent = sent + 1'b1;
                        o.status = STATUS_OK;
                    end
                end
            end
            default:
                o.status = STATUS_BAD_PARAM;
        endcase
        o.pending = pending;
        o.high_water = high_water;
        o.submitted = submitted;
        o.sent = sent;
        o.rejected = rejected;
        o.failed = failed;
        return o;
    endfunction

    function automatic void compare_field(
        input string              name,
        input logic [TOTAL_W-1:0] want,
        input logic [TOTAL_W-1:0] got
    );
        if (got !== want)
        begin
            $error("%s expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            limit_reg = LIMIT_RESET;
            occupied = '0;
            pending = '0;
            high_water = '0;
            submitted = '0;
            sent = '0;
            rejected = '0;
            failed = '0;
            outcome_q.delete();
            mismatch_count = 0;
            awaiting_count = 0;
            checked_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("response with no request outstanding");
                    mismatch_count++;
                end
                else
                begin
                    o = outcome_q.pop_front();
                    compare_field("status", TOTAL_W'(o.status), TOTAL_W'(rsp.status));
                    compare_field("chosen_slot", TOTAL_W'(o.chosen),
                                  TOTAL_W'(rsp.chosen_slot));
                    compare_field("out_handle", o.handle, rsp.out_handle);
                    compare_field("out_length", TOTAL_W'(o.length),
                                  TOTAL_W'(rsp.out_length));
                    compare_field("out_class", TOTAL_W'(o.pclass),
                                  TOTAL_W'(rsp.out_class));
                    compare_field("pending_count", TOTAL_W'(o.pending),
                                  TOTAL_W'(rsp.pending_count));
                    compare_field("high_water_mark", TOTAL_W'(o.high_water),
                                  TOTAL_W'(rsp.high_water_mark));
                    compare_field("submitted_total", o.submitted, rsp.submitted_total);
                    compare_field("sent_total", o.sent, rsp.sent_total);
                    compare_field("rejected_total", o.rejected, rsp.rejected_total);
                    compare_field("failed_total", o.failed, rsp.failed_total);
                    checked_count++;
                end
            end
            if (req.valid && req.ready)
                outcome_q.push_back(serve_request(req.operation, req.packet_class,
                    req.packet_handle, req.packet_length, req.slot_number, req.dropped));
            if (cfg_we)
                limit_reg = cfg_wdata;
            awaiting_count = outcome_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cpoq_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 240;
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
    // Top end, bottom end, two above the buffer, zero, and one in between
    localparam logic [LEN_W-1:0] LIMIT_STEPS [SEGMENTS] =
        '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd300, 11'd1025};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;
    logic [LEN_W-1:0] limit_now;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               op_count [4];
    int               mismatches;
    int               awaiting;
    int               checked;

    cpoq_req_if req ();
    cpoq_rsp_if rsp ();

    class_priority_output_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    cpoq_result_compare result_compare (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req            (req),
        .rsp            (rsp),
        .mismatch_count (mismatches),
        .awaiting_count (awaiting),
        .checked_count  (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("class_priority_output_queue: mismatch");
        $finish;
    end

    // Leaves valid high after acceptance so back-to-back requests need no toggle
    task automatic send_request(
        input logic [OP_W-1:0]       op,
        input logic [CLASS_W-1:0]    cls,
        input logic [HANDLE_W-1:0]   handle,
        input logic [LEN_IN_W-1:0]   len,
        input logic [SLOT_NUM_W-1:0] slot,
        input logic                  drop
    );
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= op;
        req.packet_class <= cls;
        req.packet_handle <= handle;
        req.packet_length <= len;
        req.slot_number <= slot;
        req.dropped <= drop;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        op_count[op]++;
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        @(negedge clk);
        req.valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        // let the block fall idle before touching the register
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        limit_now = value;
    endtask

    task automatic random_request(input bit filling);
        logic [CLASS_W-1:0]  cls;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_IN_W-1:0] len;
        logic [LEN_W-1:0]    cap;
        logic [OP_W-1:0]     op;
        int                  pick;
        int                  submit_pct;
        int                  lsel;
        cap = (limit_now > BUFFER_LIMIT) ? BUFFER_LIMIT : limit_now;
        cls = ($urandom_range(99) < 88) ? CLASS_W'($urandom_range(5)) :
                                          CLASS_W'($urandom_range(7, 6));
        handle = ($urandom_range(99) < 95) ? $urandom : '0;
        lsel = $urandom_range(99);
        if (lsel < 6)
            len = '0;
        else if (lsel < 14 || cap == '0)
            len = LEN_IN_W'($urandom);
        else if (lsel < 22)
            len = LEN_IN_W'(cap) + 1'b1;
        else if (lsel < 30)
            len = LEN_IN_W'(cap);
        else
            len = LEN_IN_W'($urandom_range(cap, 1));
        // fill towards busy, then drain
        submit_pct = filling ? 65 : 20;
        pick = $urandom_range(99);
        if (pick < submit_pct)
            op = OP_SUBMIT;
        else if (pick < submit_pct + 15)
            op = OP_SELECT;
        else if (pick < 95)
            op = OP_RETIRE;
        else
            op = OP_UNDEFINED;
        send_request(op, cls, handle, len, SLOT_NUM_W'($urandom_range(15)),
                     1'($urandom_range(1)));
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.operation = OP_SUBMIT;
        req.packet_class = '0;
        req.packet_handle = '0;
        req.packet_length = '0;
        req.slot_number = '0;
        req.dropped = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        limit_now = LIMIT_RESET;
        send_idle_pct = 8;
        recv_idle_pct = 61;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty queue, free slot, undefined code
        send_request(OP_SELECT, 3'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_request(OP_RETIRE, 3'd0, 32'd0, 16'd0, 4'd15, 1'b1);
        send_request(OP_UNDEFINED, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 4'd15, 1'b1);
        // Parameter checks, bad class ahead of too long
        send_request(OP_SUBMIT, 3'd6, 32'd1, 16'd10, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd7, 32'd0, 16'd0, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd0, 32'd0, 16'd5, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd0, 32'd5, 16'd0, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd6, 32'd9, 16'd2000, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd2, 32'd9, 16'd1017, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd2, 32'd9, 16'hFFFF, 4'd0, 1'b0);
        // Fill a few slots and check priority order and tie break
        send_request(OP_SUBMIT, 3'd0, 32'hFFFF_FFFF, 16'd1016, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd1, 32'd1, 16'd1, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd5, 32'hA5A5_5A5A, 16'd512, 4'd0, 1'b0);
        send_request(OP_SELECT, 3'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd4, 32'h1234_5678, 16'd64, 4'd0, 1'b0);
        send_request(OP_SELECT, 3'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_request(OP_RETIRE, 3'd0, 32'd0, 16'd0, 4'd3, 1'b1);
        send_request(OP_RETIRE, 3'd0, 32'd0, 16'd0, 4'd3, 1'b0);
        send_request(OP_RETIRE, 3'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_request(OP_SELECT, 3'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd3, 32'h8000_0001, 16'd2, 4'd0, 1'b0);
        send_request(OP_SELECT, 3'd0, 32'd0, 16'd0, 4'd0, 1'b0);
        send_request(OP_SUBMIT, 3'd2, 32'h0000_0100, 16'd700, 4'd0, 1'b0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            write_limit(LIMIT_STEPS[seg]);
            if (seg / 2 == 1)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 8;
            end
            else if (seg / 2 == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                random_request(((n / 30) % 2) == 0);
        end

        @(negedge clk);
        req.valid <= 1'b0;
        for (int w = 0; w < 4000 && awaiting != 0; w++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (awaiting != 0)
            $error("%0d responses never arrived", awaiting);

        $display("Run covered %0d submits, %0d selects, %0d retires, %0d undefined codes",
                 op_count[OP_SUBMIT], op_count[OP_SELECT], op_count[OP_RETIRE],
                 op_count[OP_UNDEFINED]);
        $display("across %0d payload limits; %0d responses compared", SEGMENTS + 1, checked);
        if (mismatches == 0 && awaiting == 0)
            $display("class_priority_output_queue: match");
        else
            $display("class_priority_output_queue: mismatch");
        $finish;
    end

endmodule
